### sv/gpa_pkg.sv
// shared constants, codes and types for the generational page allocator
`default_nettype none
package gpa_pkg;
  // table geometry (page size is a power of two)
  localparam int NUM_PAGES  = 256;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int NPG_W      = PAGE_W + 1;
  localparam int GEN_W      = 16;
  localparam int SLOT_W     = 16;
  localparam int MAX_PAGES  = 16'hFFFF;

  // operation codes
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_LOOKUP  = 2'd2;
  localparam logic [1:0] FN_INIT    = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_UNAVAILABLE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [2:0] ST_DENIED      = 3'd5;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       domain;
    logic [NPG_W-1:0] npages;
    logic [PAGE_W-1:0] slot;
    logic [GEN_W-1:0] gen;
    logic             early;
    logic [2:0]       early_status;
  } req_t;

  // one page table entry in memory
  typedef struct packed {
    logic [PAGE_W-1:0] head;
    logic [NPG_W-1:0]  run_len;
    logic [7:0]        owner;
    logic [GEN_W-1:0]  gen;
  } entry_t;
endpackage
`default_nettype wire

### sv/gpa_front.sv
// front end: argument checks and page count for each request
`default_nettype none
module gpa_front (
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  domain,
  input  wire logic [31:0] size_bytes,
  input  wire logic [31:0] handle_in,
  output gpa_pkg::req_t    req
);
  logic [31:0] pages;
  logic [15:0] low;
  logic [15:0] low_m1;

  // round size up to whole pages
  assign pages = (size_bytes >> gpa_pkg::PAGE_SHIFT)
               + 32'(|size_bytes[gpa_pkg::PAGE_SHIFT-1:0]);
  assign low    = handle_in[gpa_pkg::SLOT_W-1:0];
  assign low_m1 = low - 16'd1;

  // classify
  always_comb begin
    req.func         = func;
    req.domain       = domain;
    req.npages       = pages[gpa_pkg::NPG_W-1:0];
    req.slot         = low_m1[gpa_pkg::PAGE_W-1:0];
    req.gen          = handle_in[31:16];
    req.early        = 1'b0;
    req.early_status = gpa_pkg::ST_OK;
    case (func)
      gpa_pkg::FN_ALLOC: begin
        if (domain == 8'd0 || size_bytes == 32'd0) begin
          req.early        = 1'b1;
          req.early_status = gpa_pkg::ST_INVALID;
        end else if (pages > 32'(gpa_pkg::MAX_PAGES)) begin
          req.early        = 1'b1;
          req.early_status = gpa_pkg::ST_OVERFLOW;
        end else if (pages > 32'(gpa_pkg::NUM_PAGES)) begin
          req.early        = 1'b1;
          req.early_status = gpa_pkg::ST_UNAVAILABLE;
        end
      end
      gpa_pkg::FN_RELEASE, gpa_pkg::FN_LOOKUP: begin
        if (domain == 8'd0 || low == 16'd0 || low > 16'(gpa_pkg::NUM_PAGES)) begin
          req.early        = 1'b1;
          req.early_status = gpa_pkg::ST_INVALID;
        end
      end
      default: begin
        req.early = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

### sv/gpa_queue.sv
// two-entry request queue between front and back
`default_nettype none
module gpa_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  gpa_pkg::req_t      push_req,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output gpa_pkg::req_t      head_req
);
  gpa_pkg::req_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_req  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_req;
  end
endmodule
`default_nettype wire

### sv/gpa_back.sv
// back end: page table, first-fit scan, run stamping and handle checks
`default_nettype none
module gpa_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  gpa_pkg::req_t    req,
  output logic             req_pop,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      handle_out,
  output logic [19:0]      byte_offset,
  output logic             found
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_GEN   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  localparam int PW = gpa_pkg::PAGE_W;
  localparam int NW = gpa_pkg::NPG_W;

  logic [2:0] state;

  // table storage
  gpa_pkg::entry_t mem [gpa_pkg::NUM_PAGES];
  gpa_pkg::entry_t mem_q;
  logic [gpa_pkg::NUM_PAGES-1:0] active;
  logic [gpa_pkg::NUM_PAGES-1:0] gen_valid;
  logic inited;
  logic gv_q;
  logic go_q;

  // working registers
  gpa_pkg::req_t    cur;
  logic [PW-1:0]    idx;
  logic [NW-1:0]    run;
  logic [NW-1:0]    cnt;
  logic [PW-1:0]    addr;
  logic [PW-1:0]    start;
  logic [15:0]      wgen;
  logic             wset;

  logic             rd_en;
  logic [PW-1:0]    rd_addr;
  logic             wr_en;
  gpa_pkg::entry_t  wr_word;
  logic [15:0]      rd_gen;
  logic [15:0]      gen_inc;
  logic [NW-1:0]    run_next;

  assign req_pop = (state == S_IDLE) && req_valid;

  // generation as stored; never-written entries read 0, or 1 once init has run
  assign rd_gen   = gv_q ? mem_q.gen : {15'd0, go_q};
  assign gen_inc  = rd_gen + 16'd1;
  assign run_next = active[idx] ? '0 : run + NW'(1);

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur.slot;
    if (req_pop) begin
      rd_en   = 1'b1;
      rd_addr = req.slot;
    end else if (state == S_SCAN && run_next == cur.npages) begin
      rd_en   = 1'b1;
      rd_addr = idx - PW'(cur.npages - NW'(1));
    end
    wr_en           = (state == S_WRITE);
    wr_word.head    = wset ? start : '0;
    wr_word.run_len = wset ? cur.npages : '0;
    wr_word.owner   = wset ? cur.domain : 8'd0;
    wr_word.gen     = wgen;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_word;
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      gv_q  <= gen_valid[rd_addr];
      go_q  <= inited;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      active    <= '0;
      gen_valid <= '0;
      inited    <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= req_valid && (req.early || req.func == gpa_pkg::FN_INIT);
          if (req_valid) begin
            cur         <= req;
            status      <= req.early ? req.early_status : gpa_pkg::ST_OK;
            handle_out  <= 32'd0;
            byte_offset <= 20'd0;
            found       <= 1'b0;
            idx         <= '0;
            run         <= '0;
            if (req.early) begin
              state <= S_IDLE;
            end else if (req.func == gpa_pkg::FN_INIT) begin
              active <= '0;
              inited <= 1'b1;
            end else if (req.func == gpa_pkg::FN_ALLOC) begin
              state <= S_SCAN;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!active[cur.slot] || rd_gen != cur.gen || mem_q.head != cur.slot) begin
            status <= gpa_pkg::ST_NOT_FOUND;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (mem_q.owner != cur.domain) begin
            status <= gpa_pkg::ST_DENIED;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (cur.func == gpa_pkg::FN_LOOKUP) begin
            byte_offset <= 20'(32'(cur.slot) << gpa_pkg::PAGE_SHIFT);
            found       <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            // release: clear the run, advance generation skipping zero
            addr  <= cur.slot;
            cnt   <= mem_q.run_len;
            wset  <= 1'b0;
            wgen  <= (gen_inc == 16'd0) ? 16'd1 : gen_inc;
            state <= (mem_q.run_len == '0) ? S_IDLE : S_WRITE;
            done  <= (mem_q.run_len == '0);
          end
        end
        S_SCAN: begin
          // one page per cycle, first run of free pages long enough
          run  <= run_next;
          idx  <= idx + PW'(1);
          done <= (run_next != cur.npages) && (idx == PW'(gpa_pkg::NUM_PAGES - 1));
          if (run_next == cur.npages) begin
            start <= idx - PW'(cur.npages - NW'(1));
            state <= S_GEN;
          end else if (idx == PW'(gpa_pkg::NUM_PAGES - 1)) begin
            status <= gpa_pkg::ST_UNAVAILABLE;
            state  <= S_IDLE;
          end
        end
        S_GEN: begin
          done  <= 1'b0;
          addr  <= start;
          cnt   <= cur.npages;
          wset  <= 1'b1;
          wgen  <= (rd_gen == 16'd0) ? 16'd1 : rd_gen;
          state <= S_WRITE;
        end
        S_WRITE: begin
          active[addr]    <= wset;
          gen_valid[addr] <= 1'b1;
          addr <= addr + PW'(1);
          cnt  <= cnt - NW'(1);
          done <= (cnt == NW'(1) || addr == PW'(gpa_pkg::NUM_PAGES - 1));
          if (cnt == NW'(1) || addr == PW'(gpa_pkg::NUM_PAGES - 1)) begin
            if (wset) handle_out <= {wgen, 16'(32'(start) + 32'd1)};
            state <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == gpa_pkg::ST_OK))
    else $error("found without a good lookup");
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    (done && handle_out != 32'd0) |-> (status == gpa_pkg::ST_OK && cur.func == gpa_pkg::FN_ALLOC))
    else $error("handle on a failed request");
  a_write_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (cnt != '0))
    else $error("run write with empty count");
endmodule
`default_nettype wire

### sv/generational_page_allocator.sv
// top level of the generational page allocator
// channel   signals                                     handshake
// request   func domain size_bytes handle_in            start && !busy
// result    status handle_out byte_offset found         done, one cycle
// from accept to result: init and failed argument checks answer from idle; lookup
// and release read and check the entry, and a good release then clears each page of
// the run; allocate scans page by page for a first fit, then stamps each page of it
// reset clears the queue, the sequencer, active bits and generation flags at once
// busy rises only while the two-entry queue is full; results cannot be held off
`default_nettype none
module generational_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  domain,
  input  wire logic [31:0] size_bytes,
  input  wire logic [31:0] handle_in,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      handle_out,
  output logic [19:0]      byte_offset,
  output logic             found
);
  gpa_pkg::req_t f_req;
  gpa_pkg::req_t q_req;
  logic q_full;
  logic q_ne;
  logic q_pop;

  gpa_front u_front (
    .func(func), .domain(domain), .size_bytes(size_bytes),
    .handle_in(handle_in), .req(f_req)
  );

  gpa_queue u_queue (
    .clk(clk), .rst(rst), .push(start && !q_full), .push_req(f_req),
    .pop(q_pop), .full(q_full), .not_empty(q_ne), .head_req(q_req)
  );

  gpa_back u_back (
    .clk(clk), .rst(rst), .req_valid(q_ne), .req(q_req), .req_pop(q_pop),
    .done(done), .status(status), .handle_out(handle_out),
    .byte_offset(byte_offset), .found(found)
  );

  assign busy = q_full;
endmodule
`default_nettype wire

### tb/generational_page_allocator_tb.sv
// self-checking testbench for the generational page allocator
`default_nettype none
module generational_page_allocator_tb;

  // one request to the block
  typedef struct {
    logic [1:0]  func;
    logic [7:0]  domain;
    logic [31:0] size_bytes;
    logic [31:0] handle_in;
  } request_t;

  // one expected response
  typedef struct {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [19:0] byte_offset;
    logic        found;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = gpa_pkg::FN_INIT;
  logic [7:0]  domain = '0;
  logic [31:0] size_bytes = '0;
  logic [31:0] handle_in = '0;
  logic        done;
  logic [2:0]  status;
  logic [31:0] handle_out;
  logic [19:0] byte_offset;
  logic        found;

  // shadow page table
  logic        tbl_active [gpa_pkg::NUM_PAGES];
  logic [7:0]  tbl_head [gpa_pkg::NUM_PAGES];
  int unsigned tbl_len [gpa_pkg::NUM_PAGES];
  logic [7:0]  tbl_owner [gpa_pkg::NUM_PAGES];
  logic [15:0] tbl_gen [gpa_pkg::NUM_PAGES];

  request_t    pending_reqs[$];
  response_t   expected_resps[$];
  int          error_count = 0;
  int          accepted_count = 0;
  int          checked_count = 0;
  int          gap_left = 0;
  bit          stim_done = 1'b0;
  int          ok_allocs = 0;
  int          ok_lookups = 0;

  generational_page_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .domain(domain), .size_bytes(size_bytes), .handle_in(handle_in),
    .done(done), .status(status), .handle_out(handle_out),
    .byte_offset(byte_offset), .found(found)
  );

  always #10 clk = ~clk;

  // decode a handle and check it against the shadow table
  function automatic logic [2:0] vet_handle(input logic [31:0] h, input logic [7:0] d,
                                            output int unsigned slot);
    int unsigned low;
    low = 32'(h[15:0]);
    slot = 0;
    if (d == 8'd0 || low == 0 || low - 1 >= gpa_pkg::NUM_PAGES) return gpa_pkg::ST_INVALID;
    slot = low - 1;
    if (!tbl_active[slot] || tbl_gen[slot] != h[31:16]) return gpa_pkg::ST_NOT_FOUND;
    if (tbl_head[slot] != slot[7:0]) return gpa_pkg::ST_NOT_FOUND;
    if (tbl_owner[slot] != d) return gpa_pkg::ST_DENIED;
    return gpa_pkg::ST_OK;
  endfunction

  // apply one request to the shadow table and compute the response
  function automatic response_t predict_page_op(input request_t r);
    response_t   p;
    logic [32:0] npg;
    int unsigned n, s, base;
    logic [15:0] g, nxt;
    bit          fits;
    p = '{gpa_pkg::ST_OK, 32'd0, 20'd0, 1'b0};
    case (r.func)
      gpa_pkg::FN_ALLOC: begin
        npg = ({1'b0, r.size_bytes} + 33'(gpa_pkg::PAGE_BYTES - 1)) >> gpa_pkg::PAGE_SHIFT;
        if (r.domain == 8'd0 || r.size_bytes == 0) p.status = gpa_pkg::ST_INVALID;
        else if (npg > 33'hFFFF) p.status = gpa_pkg::ST_OVERFLOW;
        else begin
          n = npg[31:0];
          p.status = gpa_pkg::ST_UNAVAILABLE;
          for (base = 0; base + n <= gpa_pkg::NUM_PAGES && p.status != gpa_pkg::ST_OK;
               base++) begin
            fits = 1'b1;
            for (int i = 0; i < n; i++) if (tbl_active[base+i]) fits = 1'b0;
            if (fits) begin
              g = (tbl_gen[base] == 16'd0) ? 16'd1 : tbl_gen[base];
              for (int i = 0; i < n; i++) begin
                tbl_active[base+i] = 1'b1;
                tbl_head[base+i] = base[7:0];
                tbl_len[base+i] = n;
                tbl_owner[base+i] = r.domain;
                tbl_gen[base+i] = g;
              end
              p.handle_out = {g, 16'(base + 1)};
              p.status = gpa_pkg::ST_OK;
            end
          end
        end
      end
      gpa_pkg::FN_RELEASE: begin
        p.status = vet_handle(r.handle_in, r.domain, s);
        if (p.status == gpa_pkg::ST_OK) begin
          n = tbl_len[s];
          nxt = tbl_gen[s] + 16'd1;
          if (nxt == 16'd0) nxt = 16'd1;
          for (int i = 0; i < n && s + i < gpa_pkg::NUM_PAGES; i++) begin
            tbl_active[s+i] = 1'b0;
            tbl_head[s+i] = '0;
            tbl_len[s+i] = 0;
            tbl_owner[s+i] = '0;
            tbl_gen[s+i] = nxt;
          end
        end
      end
      gpa_pkg::FN_LOOKUP: begin
        p.status = vet_handle(r.handle_in, r.domain, s);
        if (p.status == gpa_pkg::ST_OK) begin
          p.byte_offset = 20'(s * gpa_pkg::PAGE_BYTES);
          p.found = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < gpa_pkg::NUM_PAGES; i++) begin
          tbl_active[i] = 1'b0;
          tbl_head[i] = '0;
          tbl_len[i] = 0;
          tbl_owner[i] = '0;
          if (tbl_gen[i] == 16'd0) tbl_gen[i] = 16'd1;
        end
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h (response %0d)", what, got, want,
             checked_count);
  endtask

  task automatic add_req(input logic [1:0] f, input logic [7:0] d, input logic [31:0] sz,
                         input logic [31:0] h);
    pending_reqs.push_back('{f, d, sz, h});
  endtask

  // wait until every queued request has been answered
  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_reqs.size() == 0 && !start && expected_resps.size() == 0));
  endtask

  // mostly small sizes, some large, a few absurd
  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 8 * gpa_pkg::PAGE_BYTES);
    if (k < 85) return $urandom_range(1, 64 * gpa_pkg::PAGE_BYTES);
    if (k < 93) return $urandom_range(1, 300 * gpa_pkg::PAGE_BYTES);
    return $urandom;
  endfunction

  // driver: presents queued requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) begin
        accepted_count <= accepted_count + 1;
        expected_resps.push_back(predict_page_op('{func, domain, size_bytes, handle_in}));
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        request_t r;
        r = pending_reqs.pop_front();
        start <= 1'b1;
        func <= r.func;
        domain <= r.domain;
        size_bytes <= r.size_bytes;
        handle_in <= r.handle_in;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
      end
    end
  end

  // monitor: compares each response with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected response", {29'd0, status}, 32'd0);
      end else begin
        response_t e;
        e = expected_resps.pop_front();
        if (status !== e.status) report_mismatch("status", {29'd0, status}, {29'd0, e.status});
        if (handle_out !== e.handle_out) report_mismatch("handle_out", handle_out, e.handle_out);
        if (byte_offset !== e.byte_offset)
          report_mismatch("byte_offset", {12'd0, byte_offset}, {12'd0, e.byte_offset});
        if (found !== e.found) report_mismatch("found", {31'd0, found}, {31'd0, e.found});
        if (e.status == gpa_pkg::ST_OK && e.handle_out != 0) begin
          ok_allocs++;
        end
        if (e.found) ok_lookups++;
      end
      checked_count <= checked_count + 1;
    end
  end

  // stimulus: directed then random, tracking handles for well-formed sequences
  initial begin
    int          k, idx;
    logic [7:0]  d;
    logic [31:0] h;
    for (int i = 0; i < gpa_pkg::NUM_PAGES; i++) begin
      tbl_active[i] = 1'b0;
      tbl_head[i] = '0;
      tbl_len[i] = 0;
      tbl_owner[i] = '0;
      tbl_gen[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: argument errors, overflow, generation-zero allocate, handle checks, full table and init
    add_req(gpa_pkg::FN_ALLOC, 8'd0, 32'd100, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd7, 32'd0, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd7, 32'hFFFF_FFFF, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd7, 32'h0FFF_F001, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd7, 32'h0FFF_F000, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd7, 32'd1, 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'hFF, 32'd4097, 32'd0);
    add_req(gpa_pkg::FN_LOOKUP, 8'd7, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_LOOKUP, 8'hFF, 32'd0, {16'd1, 16'd2});
    add_req(gpa_pkg::FN_LOOKUP, 8'hFF, 32'd0, {16'd1, 16'd3});
    add_req(gpa_pkg::FN_LOOKUP, 8'd8, 32'd0, {16'd1, 16'd2});
    add_req(gpa_pkg::FN_LOOKUP, 8'd7, 32'd0, {16'd2, 16'd1});
    add_req(gpa_pkg::FN_LOOKUP, 8'd0, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_RELEASE, 8'd7, 32'd0, 32'h0000_0000);
    add_req(gpa_pkg::FN_RELEASE, 8'd7, 32'd0, 32'hFFFF_0101);
    add_req(gpa_pkg::FN_RELEASE, 8'd7, 32'd0, 32'hFFFF_FFFF);
    add_req(gpa_pkg::FN_RELEASE, 8'd7, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_LOOKUP, 8'd7, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_ALLOC, 8'd9, 32'(gpa_pkg::NUM_PAGES * gpa_pkg::PAGE_BYTES), 32'd0);
    add_req(gpa_pkg::FN_ALLOC, 8'd9, 32'd1, 32'd0);
    add_req(gpa_pkg::FN_INIT, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(gpa_pkg::FN_ALLOC, 8'd9, 32'(gpa_pkg::NUM_PAGES * gpa_pkg::PAGE_BYTES), 32'd0);
    add_req(gpa_pkg::FN_LOOKUP, 8'd9, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_RELEASE, 8'd9, 32'd0, {16'd1, 16'd1});
    add_req(gpa_pkg::FN_INIT, 8'd0, 32'd0, 32'd0);
    wait_idle();

    // random: handles are rebuilt from the shadow table that the predictor keeps
    for (int n = 0; n < 1700; n++) begin
      k = $urandom_range(0, 99);
      d = 8'($urandom_range(1, 4));
      if (k < 35) begin
        add_req(gpa_pkg::FN_ALLOC, ($urandom_range(0, 19) == 0) ? 8'($urandom) : d,
                pick_size(), $urandom);
      end else if (k < 92) begin
        // rebuild a live handle from the shadow table at queue time
        idx = $urandom_range(0, gpa_pkg::NUM_PAGES - 1);
        while (idx > 0 && !(tbl_active[idx] && tbl_head[idx] == idx)) idx--;
        h = {tbl_gen[idx], 16'(idx + 1)};
        d = tbl_owner[idx];
        if ($urandom_range(0, 9) == 0) d = 8'($urandom);
        if ($urandom_range(0, 9) == 0) h = $urandom;
        if ($urandom_range(0, 14) == 0) h[15:0] = 16'(idx + 2);
        if ($urandom_range(0, 14) == 0) h[31:16] = h[31:16] + 16'd1;
        add_req((k < 64) ? gpa_pkg::FN_LOOKUP : gpa_pkg::FN_RELEASE, d, $urandom, h);
      end else if (k < 94) begin
        add_req(gpa_pkg::FN_INIT, 8'($urandom), $urandom, $urandom);
      end else begin
        add_req(2'($urandom), 8'($urandom), $urandom, $urandom);
      end
      // keep the shadow table in step so handles stay mostly live
      wait_idle();
    end
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    repeat (600) @(posedge clk);
    $display("covered %0d requests, %0d responses checked, %0d allocations, %0d lookups hit",
             accepted_count, checked_count, ok_allocs, ok_lookups);
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("generational_page_allocator regression: pass");
    end else begin
      $display("%0d mismatches, %0d responses missing", error_count, expected_resps.size());
      $display("generational_page_allocator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout waiting for responses");
    $display("generational_page_allocator regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
sv/gpa_pkg.sv
sv/gpa_front.sv
sv/gpa_queue.sv
sv/gpa_back.sv
sv/generational_page_allocator.sv
tb/generational_page_allocator_tb.sv
